// ===== rtl/cqb_pkg.sv =====
package cqb_pkg;

    // Queue geometry and field widths.
    localparam int QUEUE_DEPTH = 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 2;
    localparam int ST_W        = 2;

    // Command codes carried by each input transaction.
    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_PEEK = 2'd2,
        CMD_DISP = 2'd3
    } cmd_t;

    // Status codes returned with each result transaction.
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ_ONE,
        S_READ_DISP,
        S_WALK
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    wr_en;       // write value_in at the tail and advance it
        logic    head_adv;    // advance the head and drop one word
        logic    rd_en;       // start a memory read
        logic    rd_walk;     // read at the walk pointer instead of the head
        logic    walk_init;   // start a display walk from the head
        logic    walk_next;   // step the walk pointer
        logic    load_imm;    // load a result with no data word
        status_t imm_status;  // status for an immediate result
        logic    load_data;   // load a result from the memory read data
        logic    disp;        // the data result belongs to a display walk
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic rem_last;  // one display word left to emit
        logic out_busy;  // result register occupied and not taken this cycle
    } dp_stat_t;

    // Circular index step.
    function automatic logic [IDX_W-1:0] adv_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(QUEUE_DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + IDX_W'(1);
        end
        return res;
    endfunction

endpackage

// ===== rtl/circular_queue_buffer.sv =====
// Channel  Handshake            Payload
// -------  -------------------  ---------------------------
// input    in_valid / in_stall  command, value_in
// output   out_valid/out_stall  value_out, status, last
//
// Enqueue and every empty or full report give one result in the cycle after the input
// transaction; dequeue and peek give it via the registered read port and the result
// register. Display gives one result per stored word, each read and loaded before the
// next read; a held result delays the next read. A new input is taken in the cycle after
// the last result of the previous one is loaded, if that result is not held by out_stall.
// Reset (rst_n low) empties the queue at once; stored words are not cleared.
module circular_queue_buffer
    import cqb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [CMD_W-1:0]         command,
    input  logic signed [DATA_W-1:0] value_in,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] value_out,
    output logic [ST_W-1:0]          status,
    output logic                     last
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // Command sequencing.
    cqb_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command (command),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    // Storage, pointers and result register.
    cqb_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (dp_cmd),
        .stat     (dp_stat),
        .value_in (value_in),
        .value_out(value_out),
        .status   (status),
        .last     (last),
        .out_valid(out_valid),
        .out_stall(out_stall)
    );

endmodule

// ===== rtl/cqb_ram.sv =====
module cqb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/cqb_datapath.sv =====
module cqb_datapath
    import cqb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    input  logic signed [DATA_W-1:0] value_in,
    output logic signed [DATA_W-1:0] value_out,
    output logic [ST_W-1:0]          status,
    output logic                     last,
    output logic                     out_valid,
    input  logic                     out_stall
);

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [IDX_W-1:0]  walk_reg, walk_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] value_reg, value_next;
    status_t           status_reg, status_next;
    logic              last_reg, last_next;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              out_take;

    // Entry store.
    assign rd_addr = cmd.rd_walk ? walk_reg : head_reg;

    cqb_ram #(
        .WIDTH(DATA_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .clk    (clk),
        .wr_en  (cmd.wr_en),
        .wr_addr(tail_reg),
        .wr_data(value_in),
        .rd_en  (cmd.rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Pointer, occupancy and walk counter updates.
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        walk_next = walk_reg;
        rem_next  = rem_reg;
        if (cmd.wr_en)
        begin
            tail_next = adv_idx(tail_reg);
            occ_next  = occ_reg + CNT_W'(1);
        end
        if (cmd.head_adv)
        begin
            head_next = adv_idx(head_reg);
            occ_next  = occ_reg - CNT_W'(1);
        end
        if (cmd.walk_init)
        begin
            walk_next = adv_idx(head_reg);
            rem_next  = occ_reg;
        end
        if (cmd.walk_next)
        begin
            walk_next = adv_idx(walk_reg);
        end
        if (cmd.load_data && cmd.disp)
        begin
            rem_next = rem_reg - CNT_W'(1);
        end
    end

    // Result register: freed when taken, loaded by the controller.
    assign out_take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_take;
        value_next     = value_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        if (cmd.load_imm)
        begin
            out_valid_next = 1'b1;
            value_next     = '0;
            status_next    = cmd.imm_status;
            last_next      = 1'b1;
        end
        else if (cmd.load_data)
        begin
            out_valid_next = 1'b1;
            value_next     = rd_data;
            status_next    = ST_OK;
            last_next      = !cmd.disp || (rem_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            walk_reg      <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            walk_reg      <= walk_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    // Status back to the controller.
    assign stat.full     = (occ_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty    = (occ_reg == '0);
    assign stat.rem_last = (rem_reg == CNT_W'(1));
    assign stat.out_busy = out_valid_reg && out_stall;

    assign value_out = value_reg;
    assign status    = ST_W'(status_reg);
    assign last      = last_reg;
    assign out_valid = out_valid_reg;

    // Occupancy never runs past the depth.
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    // A write is only committed while there is room.
    a_wr_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> !stat.full)
        else $error("write into a full queue");

    // A word is only removed from a non-empty queue.
    a_rd_word: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.head_adv |-> !stat.empty)
        else $error("head advanced on an empty queue");

    // A new result never overwrites one still waiting to be taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_imm || cmd.load_data) |-> !stat.out_busy)
        else $error("result register overwritten");

    // An empty queue has head and tail together.
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        stat.empty |-> (head_reg == tail_reg))
        else $error("head and tail differ on an empty queue");

endmodule

// ===== rtl/cqb_ctrl.sv =====
module cqb_ctrl
    import cqb_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [CMD_W-1:0] command,
    input  dp_stat_t        stat,
    output dp_cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   accept;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // An input transaction is taken only in idle with the result register free.
    assign in_stall = !((state_reg == S_IDLE) && !stat.out_busy);
    assign accept   = in_valid && !in_stall;

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.imm_status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_t'(command))
                        CMD_ENQ:
                        begin
                            cmd.load_imm = 1'b1;
                            if (stat.full)
                            begin
                                cmd.imm_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.wr_en = 1'b1;
                            end
                        end
                        CMD_DEQ, CMD_PEEK:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load_imm   = 1'b1;
                                cmd.imm_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.rd_en    = 1'b1;
                                cmd.head_adv = (cmd_t'(command) == CMD_DEQ);
                                state_next   = S_READ_ONE;
                            end
                        end
                        CMD_DISP:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load_imm   = 1'b1;
                                cmd.imm_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.rd_en     = 1'b1;
                                cmd.walk_init = 1'b1;
                                state_next    = S_READ_DISP;
                            end
                        end
                    endcase
                end
            end
            S_READ_ONE:
            begin
                cmd.load_data = 1'b1;
                state_next    = S_IDLE;
            end
            S_READ_DISP:
            begin
                cmd.load_data = 1'b1;
                cmd.disp      = 1'b1;
                state_next    = stat.rem_last ? S_IDLE : S_WALK;
            end
            S_WALK:
            begin
                // Fetch the next word once the previous result is on its way.
                if (!stat.out_busy)
                begin
                    cmd.rd_en     = 1'b1;
                    cmd.rd_walk   = 1'b1;
                    cmd.walk_next = 1'b1;
                    state_next    = S_READ_DISP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A read is always followed by loading its data.
    a_rd_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |=> cmd.load_data)
        else $error("memory read without a following result load");

    // Inputs are only taken while idle.
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (state_reg == S_IDLE))
        else $error("input taken outside idle");

    // A walk step never starts while the result register is held.
    a_walk_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_next |-> !stat.out_busy)
        else $error("walk step with the result register held");

endmodule
